@@ rtl/core/sbsg_pkg.sv @@
// Shared types, constants and helper functions of the sine burst source generator.
package sbsg_pkg;

  localparam int unsigned AngleBitsDef = 32;
  localparam int unsigned ValueBitsDef = 24;
  localparam int unsigned CordicIters  = 30;
  localparam int unsigned CordicW      = 34;
  localparam int unsigned AddrBits     = 5;
  localparam logic signed [CordicW-1:0] CordicX0 = CordicW'(652032874);
  localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;

  typedef enum logic [2:0] {
    REG_PULSE_MODE   = 3'd0,
    REG_AMPLITUDE    = 3'd1,
    REG_CONT_STEP    = 3'd2,
    REG_PHASE_OFFSET = 3'd3,
    REG_CARRIER_STEP = 3'd4,
    REG_WINDOW_STEP  = 3'd5,
    REG_PULSE_LENGTH = 3'd6
  } sbsg_reg_e;

  typedef struct packed {
    logic        pulse_mode;
    logic [31:0] cont_step;
    logic [31:0] phase_offset;
    logic [31:0] carrier_step;
    logic [31:0] window_step;
    logic [31:0] pulse_length;
  } sbsg_cfg_t;

  typedef struct packed {
    logic pulse_mode;
    logic active;
    logic flip_a;
    logic flip_b;
  } sbsg_tag_t;

  function automatic logic signed [CordicW-1:0] atan_turn(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h2000_0000;
      1:  v = 32'h12E4_051E;
      2:  v = 32'h09FB_385B;
      3:  v = 32'h0511_11D4;
      4:  v = 32'h028B_0D43;
      5:  v = 32'h0145_D7E1;
      6:  v = 32'h00A2_F61E;
      7:  v = 32'h0051_7C55;
      8:  v = 32'h0028_BE53;
      9:  v = 32'h0014_5F2F;
      10: v = 32'h000A_2F98;
      11: v = 32'h0005_17CC;
      12: v = 32'h0002_8BE6;
      13: v = 32'h0001_45F3;
      14: v = 32'h0000_A2FA;
      15: v = 32'h0000_517D;
      16: v = 32'h0000_28BE;
      17: v = 32'h0000_145F;
      18: v = 32'h0000_0A30;
      19: v = 32'h0000_0518;
      20: v = 32'h0000_028C;
      21: v = 32'h0000_0146;
      22: v = 32'h0000_00A3;
      23: v = 32'h0000_0051;
      24: v = 32'h0000_0029;
      25: v = 32'h0000_0014;
      26: v = 32'h0000_000A;
      27: v = 32'h0000_0005;
      28: v = 32'h0000_0003;
      29: v = 32'h0000_0001;
      default: v = 32'h0000_0000;
    endcase
    return CordicW'(v);
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [CordicW-1:0] v);
    logic signed [CordicW-1:0] one;
    one = CordicW'(OneQ30);
    if (v > one) begin
      return OneQ30;
    end else if (v < -one) begin
      return -OneQ30;
    end
    return v[31:0];
  endfunction

endpackage

@@ rtl/core/sbsg_cfg.sv @@
// APB register file holding the mode, amplitude and phase settings.
module sbsg_cfg #(
  parameter int unsigned VALUE_BITS = sbsg_pkg::ValueBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sbsg_pkg::AddrBits-1:0]         paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  output sbsg_pkg::sbsg_cfg_t                   cfg_o,
  output logic signed [VALUE_BITS-1:0]          amplitude_o
);
  import sbsg_pkg::*;

  sbsg_cfg_t              cfg_q, cfg_d;
  logic [VALUE_BITS-1:0]  amp_q, amp_d;
  sbsg_reg_e              idx;

  assign idx    = sbsg_reg_e'(paddr[AddrBits-1:2]);
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    amp_d = amp_q;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_PULSE_MODE:   cfg_d.pulse_mode   = pwdata[0];
        REG_AMPLITUDE:    amp_d              = pwdata[VALUE_BITS-1:0];
        REG_CONT_STEP:    cfg_d.cont_step    = pwdata;
        REG_PHASE_OFFSET: cfg_d.phase_offset = pwdata;
        REG_CARRIER_STEP: cfg_d.carrier_step = pwdata;
        REG_WINDOW_STEP:  cfg_d.window_step  = pwdata;
        REG_PULSE_LENGTH: cfg_d.pulse_length = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PULSE_MODE:   prdata = {31'b0, cfg_q.pulse_mode};
      REG_AMPLITUDE:    prdata = 32'(amp_q);
      REG_CONT_STEP:    prdata = cfg_q.cont_step;
      REG_PHASE_OFFSET: prdata = cfg_q.phase_offset;
      REG_CARRIER_STEP: prdata = cfg_q.carrier_step;
      REG_WINDOW_STEP:  prdata = cfg_q.window_step;
      REG_PULSE_LENGTH: prdata = cfg_q.pulse_length;
      default:          prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      amp_q <= '0;
    end else begin
      cfg_q <= cfg_d;
      amp_q <= amp_d;
    end
  end

  assign cfg_o       = cfg_q;
  assign amplitude_o = amp_q;
endmodule

@@ rtl/core/sbsg_phase.sv @@
// Phase generation stages: step capture, phase multiply and quadrant fold.
module sbsg_phase #(
  parameter int unsigned ANGLE_BITS = sbsg_pkg::AngleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sbsg_pkg::sbsg_cfg_t    cfg_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [31:0]            step_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic signed [31:0]     za_o,
  output logic signed [31:0]     zb_o,
  output sbsg_pkg::sbsg_tag_t    tag_o
);
  import sbsg_pkg::*;

  logic                  v1_q, v2_q, v3_q;
  logic                  en1, en2, en3;
  logic [31:0]           step_q;
  logic [ANGLE_BITS-1:0] pa_q, pb_q;
  logic                  mode_q, act_q;
  logic [63:0]           mul_a, mul_b, off64;
  logic [ANGLE_BITS-1:0] sum_a;
  logic [31:0]           ta, tb;
  logic signed [31:0]    za_q, zb_q;
  sbsg_tag_t             tag_q;

  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  assign mul_a = {32'b0, step_q} *
                 {32'b0, (cfg_i.pulse_mode ? cfg_i.window_step : cfg_i.cont_step)};
  assign mul_b = {32'b0, step_q} * {32'b0, cfg_i.carrier_step};
  assign off64 = {32'b0, cfg_i.phase_offset};
  assign sum_a = pa_q + (mode_q ? '0 : off64[ANGLE_BITS-1:0]);

  if (ANGLE_BITS >= 32) begin : g_trunc
    assign ta = sum_a[ANGLE_BITS-1 -: 32];
    assign tb = pb_q[ANGLE_BITS-1 -: 32];
  end else begin : g_pad
    assign ta = {sum_a, {(32-ANGLE_BITS){1'b0}}};
    assign tb = {pb_q, {(32-ANGLE_BITS){1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      step_q <= step_i;
    end
    if (en2) begin
      pa_q   <= mul_a[ANGLE_BITS-1:0];
      pb_q   <= mul_b[ANGLE_BITS-1:0];
      mode_q <= cfg_i.pulse_mode;
      act_q  <= cfg_i.pulse_mode && (step_q < cfg_i.pulse_length);
    end
    if (en3) begin
      za_q              <= {ta[31] ^ (ta[31] ^ ta[30]), ta[30:0]};
      zb_q              <= {tb[31] ^ (tb[31] ^ tb[30]), tb[30:0]};
      tag_q.flip_a      <= ta[31] ^ ta[30];
      tag_q.flip_b      <= tb[31] ^ tb[30];
      tag_q.pulse_mode  <= mode_q;
      tag_q.active      <= act_q;
    end
  end

  assign valid_o = v3_q;
  assign za_o    = za_q;
  assign zb_o    = zb_q;
  assign tag_o   = tag_q;
endmodule

@@ rtl/core/sbsg_cordic.sv @@
// Two-lane rotation CORDIC with one register stage per iteration.
module sbsg_cordic (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic signed [31:0]                     za_i,
  input  logic signed [31:0]                     zb_i,
  input  sbsg_pkg::sbsg_tag_t                    tag_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic signed [sbsg_pkg::CordicW-1:0]    xa_o,
  output logic signed [sbsg_pkg::CordicW-1:0]    ya_o,
  output logic signed [sbsg_pkg::CordicW-1:0]    yb_o,
  output sbsg_pkg::sbsg_tag_t                    tag_o
);
  import sbsg_pkg::*;

  localparam int unsigned N = CordicIters;

  logic                      v_q   [N];
  logic                      en    [N+1];
  logic signed [CordicW-1:0] xa_q  [N];
  logic signed [CordicW-1:0] ya_q  [N];
  logic signed [CordicW-1:0] za_q  [N];
  logic signed [CordicW-1:0] xb_q  [N];
  logic signed [CordicW-1:0] yb_q  [N];
  logic signed [CordicW-1:0] zb_q  [N];
  sbsg_tag_t                 tag_q [N];

  assign en[N]   = ready_i;
  assign ready_o = en[0];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic                      v_in;
    logic signed [CordicW-1:0] xa_in, ya_in, za_in, xb_in, yb_in, zb_in;
    logic signed [CordicW-1:0] xa_d, ya_d, za_d, xb_d, yb_d, zb_d;
    sbsg_tag_t                 tag_in;

    if (g == 0) begin : g_first
      assign v_in   = valid_i;
      assign xa_in  = CordicX0;
      assign ya_in  = '0;
      assign za_in  = CordicW'(za_i);
      assign xb_in  = CordicX0;
      assign yb_in  = '0;
      assign zb_in  = CordicW'(zb_i);
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = v_q[g-1];
      assign xa_in  = xa_q[g-1];
      assign ya_in  = ya_q[g-1];
      assign za_in  = za_q[g-1];
      assign xb_in  = xb_q[g-1];
      assign yb_in  = yb_q[g-1];
      assign zb_in  = zb_q[g-1];
      assign tag_in = tag_q[g-1];
    end

    assign en[g] = !v_q[g] || en[g+1];

    always_comb begin
      if (!za_in[CordicW-1]) begin
        xa_d = xa_in - (ya_in >>> g);
        ya_d = ya_in + (xa_in >>> g);
        za_d = za_in - atan_turn(g);
      end else begin
        xa_d = xa_in + (ya_in >>> g);
        ya_d = ya_in - (xa_in >>> g);
        za_d = za_in + atan_turn(g);
      end
      if (!zb_in[CordicW-1]) begin
        xb_d = xb_in - (yb_in >>> g);
        yb_d = yb_in + (xb_in >>> g);
        zb_d = zb_in - atan_turn(g);
      end else begin
        xb_d = xb_in + (yb_in >>> g);
        yb_d = yb_in - (xb_in >>> g);
        zb_d = zb_in + atan_turn(g);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en[g]) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[g]) begin
        xa_q[g]  <= xa_d;
        ya_q[g]  <= ya_d;
        za_q[g]  <= za_d;
        xb_q[g]  <= xb_d;
        yb_q[g]  <= yb_d;
        zb_q[g]  <= zb_d;
        tag_q[g] <= tag_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign xa_o    = xa_q[N-1];
  assign ya_o    = ya_q[N-1];
  assign yb_o    = yb_q[N-1];
  assign tag_o   = tag_q[N-1];
endmodule

@@ rtl/core/sbsg_scale.sv @@
// Window, amplitude scaling, rounding and saturation stages with the output register.
module sbsg_scale #(
  parameter int unsigned VALUE_BITS = sbsg_pkg::ValueBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [VALUE_BITS-1:0]          amplitude_i,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [sbsg_pkg::CordicW-1:0]   xa_i,
  input  logic signed [sbsg_pkg::CordicW-1:0]   ya_i,
  input  logic signed [sbsg_pkg::CordicW-1:0]   yb_i,
  input  sbsg_pkg::sbsg_tag_t                   tag_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [VALUE_BITS-1:0]          drive_o,
  output logic                                  active_o
);
  import sbsg_pkg::*;

  localparam int unsigned QW = VALUE_BITS + 32;
  localparam int unsigned RW = VALUE_BITS + 2;

  logic                   v1_q, v2_q, v3_q, v4_q, v5_q;
  logic                   en1, en2, en3, en4, en5;
  sbsg_tag_t              t1_q, t2_q, t3_q, t4_q;
  logic signed [31:0]     sa_q, sb_q, h_q, sa2_q, m_q;
  logic signed [63:0]     p_q, p_rnd;
  logic signed [QW-1:0]   q_q, q_rnd;
  logic signed [RW-1:0]   r, hi, lo;
  logic signed [32:0]     diff;
  logic signed [31:0]     cwa;
  logic signed [VALUE_BITS-1:0] sat;

  assign en5     = !v5_q || ready_i;
  assign en4     = !v4_q || en5;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  assign cwa  = clamp_q30(tag_i.flip_a ? -xa_i : xa_i);
  assign diff = 33'(OneQ30) - 33'(cwa);

  assign p_rnd = p_q + 64'sd536870912;
  assign q_rnd = q_q + (QW'(1) <<< 29);
  assign r     = q_rnd[QW-1:30];
  assign hi    = RW'({1'b0, {(VALUE_BITS-1){1'b1}}});
  assign lo    = -hi - RW'(1);

  always_comb begin
    if (r > hi) begin
      sat = hi[VALUE_BITS-1:0];
    end else if (r < lo) begin
      sat = lo[VALUE_BITS-1:0];
    end else begin
      sat = r[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sa_q <= clamp_q30(tag_i.flip_a ? -ya_i : ya_i);
      sb_q <= clamp_q30(tag_i.flip_b ? -yb_i : yb_i);
      h_q  <= diff[32:1];
      t1_q <= tag_i;
    end
    if (en2) begin
      p_q   <= 64'(h_q) * 64'(sb_q);
      sa2_q <= sa_q;
      t2_q  <= t1_q;
    end
    if (en3) begin
      m_q  <= t2_q.pulse_mode ? p_rnd[61:30] : sa2_q;
      t3_q <= t2_q;
    end
    if (en4) begin
      q_q  <= QW'(amplitude_i) * QW'(m_q);
      t4_q <= t3_q;
    end
    if (en5) begin
      drive_o  <= (t4_q.pulse_mode && !t4_q.active) ? '0 : sat;
      active_o <= t4_q.active;
    end
  end

  assign valid_o = v5_q;
endmodule

@@ rtl/core/sine_burst_source_generator_core.sv @@
// Top level of the Hann-windowed sine tone-burst source generator.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+------------------------------------
//   input   | in        | in_valid_i / in_ready_o | time_step_i
//   output  | out       | out_valid_o/out_ready_i | drive_value_o, burst_active_o
//   config  | in        | psel, penable, pready   | pwrite, paddr, pwdata, prdata
//
// One transfer is accepted per cycle while in_ready_o is high, and each result is offered once it
// has passed every register stage. The 38 register stages are three phase stages, thirty CORDIC
// iteration stages and five scaling stages. Every stage advances when it is empty or its
// successor advances, so a stalled output fills bubbles first. Reset clears the valid bits
// and the configuration registers.
module sine_burst_source_generator_core #(
  parameter int unsigned ANGLE_BITS = sbsg_pkg::AngleBitsDef,
  parameter int unsigned VALUE_BITS = sbsg_pkg::ValueBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sbsg_pkg::AddrBits-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [31:0]                     time_step_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [VALUE_BITS-1:0]    drive_value_o,
  output logic                            burst_active_o
);
  import sbsg_pkg::*;

  sbsg_cfg_t                    cfg;
  logic signed [VALUE_BITS-1:0] amplitude;
  logic                         ph_valid, ph_ready, co_valid, co_ready;
  logic signed [31:0]           za, zb;
  sbsg_tag_t                    ph_tag, co_tag;
  logic signed [CordicW-1:0]    xa, ya, yb;

  sbsg_cfg #(.VALUE_BITS(VALUE_BITS)) u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg), .amplitude_o(amplitude)
  );

  sbsg_phase #(.ANGLE_BITS(ANGLE_BITS)) u_phase (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .valid_i(in_valid_i), .ready_o(in_ready_o), .step_i(time_step_i),
    .valid_o(ph_valid), .ready_i(ph_ready), .za_o(za), .zb_o(zb), .tag_o(ph_tag)
  );

  sbsg_cordic u_cordic (
    .clk_i, .rst_ni,
    .valid_i(ph_valid), .ready_o(ph_ready), .za_i(za), .zb_i(zb), .tag_i(ph_tag),
    .valid_o(co_valid), .ready_i(co_ready), .xa_o(xa), .ya_o(ya), .yb_o(yb), .tag_o(co_tag)
  );

  sbsg_scale #(.VALUE_BITS(VALUE_BITS)) u_scale (
    .clk_i, .rst_ni, .amplitude_i(amplitude),
    .valid_i(co_valid), .ready_o(co_ready), .xa_i(xa), .ya_i(ya), .yb_i(yb), .tag_i(co_tag),
    .valid_o(out_valid_o), .ready_i(out_ready_i),
    .drive_o(drive_value_o), .active_o(burst_active_o)
  );
endmodule

@@ verif/sine_burst_source_generator_core_tb.sv @@
// Self-checking testbench of the sine burst source generator core, with its own predictor.
module sine_burst_source_generator_core_tb;
  import sbsg_pkg::*;

  localparam int unsigned LatencyCycles = 38;
  localparam longint      CycleLimit    = 400000;
  localparam longint      OneTurnQ30    = 64'sd1073741824;

  typedef struct {
    logic signed [23:0] drive;
    logic               active;
  } drive_result_t;

  typedef struct {
    logic [31:0] step;
    bit          typed;
    logic [23:0] drive;
    logic        active;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] time_step_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [23:0] drive_value_o;
  logic        burst_active_o;

  sine_burst_source_generator_core dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the configuration registers.
  logic        m_pulse_mode;
  logic signed [23:0] m_amplitude;
  logic [31:0] m_cont_step, m_phase_offset, m_carrier_step, m_window_step, m_pulse_length;

  drive_result_t expected_drives[$];
  int  mismatches = 0;
  int  send_idle_pct = 0, recv_idle_pct = 0;
  longint cycle_count = 0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint limit_one(longint v);
    if (v > OneTurnQ30) return OneTurnQ30;
    if (v < -OneTurnQ30) return -OneTurnQ30;
    return v;
  endfunction

  function automatic longint round_q30_product(longint a, longint b);
    return floor_shift(a * b + 64'sd536870912, 30);
  endfunction

  function automatic void rotate_sincos(input logic [31:0] angle, output longint s_out,
                                        output longint c_out);
    longint x, y, z, dx, dy;
    bit     flip;
    logic [31:0] ang;
    ang  = angle;
    flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
    if (flip) begin
      ang = ang - 32'h8000_0000;
    end
    z = longint'($signed(ang));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s_out = limit_one(y);
    c_out = limit_one(x);
  endfunction

  function automatic drive_result_t predict_drive(logic [31:0] step);
    drive_result_t r;
    longint s, c, sw, cw, v;
    r.drive  = '0;
    r.active = 1'b0;
    v = 0;
    if (!m_pulse_mode) begin
      rotate_sincos(step * m_cont_step + m_phase_offset, s, c);
      v = round_q30_product(longint'(m_amplitude), s);
    end else if (step < m_pulse_length) begin
      r.active = 1'b1;
      rotate_sincos(step * m_window_step, sw, cw);
      rotate_sincos(step * m_carrier_step, s, c);
      v = round_q30_product(longint'(m_amplitude),
                            round_q30_product(floor_shift(OneTurnQ30 - cw, 1), s));
    end else begin
      return r;
    end
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    r.drive = v[23:0];
    return r;
  endfunction

  task automatic write_register(sbsg_reg_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AddrBits'(4 * int'(idx)); pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_PULSE_MODE:   m_pulse_mode   = value[0];
      REG_AMPLITUDE:    m_amplitude    = value[23:0];
      REG_CONT_STEP:    m_cont_step    = value;
      REG_PHASE_OFFSET: m_phase_offset = value;
      REG_CARRIER_STEP: m_carrier_step = value;
      REG_WINDOW_STEP:  m_window_step  = value;
      REG_PULSE_LENGTH: m_pulse_length = value;
      default: ;
    endcase
  endtask

  task automatic configure(logic mode, logic [31:0] amp, logic [31:0] cs, logic [31:0] po,
                           logic [31:0] ks, logic [31:0] ws, logic [31:0] len);
    write_register(REG_PULSE_MODE, {31'h0, mode});
    write_register(REG_AMPLITUDE, amp);
    write_register(REG_CONT_STEP, cs);
    write_register(REG_PHASE_OFFSET, po);
    write_register(REG_CARRIER_STEP, ks);
    write_register(REG_WINDOW_STEP, ws);
    write_register(REG_PULSE_LENGTH, len);
  endtask

  task automatic send_step(logic [31:0] step);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    time_step_i <= step;
    do @(posedge clk_i); while (!in_ready_o);
    expected_drives.push_back(predict_drive(step));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: drive %0d active %0b",
                                       drive_value_o, burst_active_o);
      end else begin
        drive_result_t e;
        e = expected_drives.pop_front();
        if (e.drive !== drive_value_o || e.active !== burst_active_o) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: drive exp %0d got %0d, active exp %0b got %0b",
                                         e.drive, drive_value_o, e.active, burst_active_o);
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic random_phase(int n);
    logic [31:0] len;
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) begin
        drain_results();
        len = ($urandom_range(3) == 0) ? $urandom : $urandom_range(300);
        configure($urandom_range(1), $urandom, $urandom, $urandom, $urandom, $urandom, len);
      end
      if (m_pulse_mode && $urandom_range(3) != 0 && m_pulse_length != 0) begin
        send_step($urandom_range(m_pulse_length > 400 ? 400 : m_pulse_length + 5));
      end else begin
        send_step($urandom);
      end
    end
  endtask

  stim_row_t directed_rows[$];

  initial begin
    m_pulse_mode = 0; m_amplitude = 0; m_cont_step = 0; m_phase_offset = 0;
    m_carrier_step = 0; m_window_step = 0; m_pulse_length = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the amplitude is zero, so every step gives zero.
    directed_rows = '{'{32'h0, 1'b1, 24'h0, 1'b0}, '{32'hFFFF_FFFF, 1'b1, 24'h0, 1'b0}};
    foreach (directed_rows[i]) begin
      send_step(directed_rows[i].step);
      if (directed_rows[i].typed) begin
        expected_drives[$].drive  = directed_rows[i].drive;
        expected_drives[$].active = directed_rows[i].active;
      end
    end
    drain_results();

    // Continuous mode at full positive amplitude with quarter turns, then at full negative amplitude.
    configure(1'b0, 32'hFF7F_FFFF, 32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    for (int i = 0; i < 6; i++) send_step(i);
    send_step(32'hFFFF_FFFF);
    drain_results();
    configure(1'b0, 32'h0080_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_step(i);
    drain_results();
    // Burst mode: inside, at the edge and after the burst, and a zero length.
    configure(1'b1, 32'h007F_FFFF, 32'h0, 32'h0, 32'h1000_0000, 32'h0800_0000, 32'd8);
    for (int i = 0; i < 10; i++) send_step(i);
    send_step(32'hFFFF_FFFF);
    drain_results();
    configure(1'b1, 32'h007F_FFFF, 32'h0, 32'h0, 32'h1000_0000, 32'h0800_0000, 32'd0);
    send_step(0);
    send_step(32'hFFFF_FFFF);
    drain_results();

    send_idle_pct = 30; recv_idle_pct = 61;
    random_phase(530);
    send_idle_pct = 61; recv_idle_pct = 30;
    random_phase(530);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(540);
    drain_results();

    if (mismatches == 0 && expected_drives.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
